FILE: hdl/lwmm_pkg.sv
// ----------------------------------------------------------------------------
// lwmm_pkg
// Shared types, constants and helpers for the line window max/min filter.
// ----------------------------------------------------------------------------
package lwmm_pkg;

    localparam int PIX_W          = 32;
    localparam int KEY_W          = 27;
    localparam int RADIUS_W       = 6;
    localparam int LEN_W          = 13;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 13;
    localparam int MAX_RADIUS_DEF = 63;
    localparam int MAX_LINE_DEF   = 4096;

    localparam logic [CFG_IDX_W-1:0] REG_RADIUS      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_MODE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH = 2'd2;

    localparam logic [RADIUS_W-1:0] RADIUS_RST      = 6'd1;
    localparam logic [LEN_W-1:0]    LINE_LENGTH_RST = 13'd1920;

    // commands from the sequencer to the datapath
    typedef struct packed {
        logic capture;
        logic store;
        logic suf_rd;
        logic suf_step;
        logic scan_init;
        logic scan_rd;
        logic scan_step;
        logic xb_rd;
        logic xb_sel;
        logic pix_rd;
        logic emit;
        logic advance;
    } lwmm_cmd_t;

    // status from the datapath to the sequencer
    typedef struct packed {
        logic end_blk;
        logic r_zero;
        logic suf_last;
        logic need_emit;
        logic same_blk;
        logic scan_done;
        logic out_free;
        logic line_last;
        logic at_final;
    } lwmm_stat_t;

    // a strictly better than b
    function automatic logic better(input logic min_mode,
                                    input logic [KEY_W-1:0] a,
                                    input logic [KEY_W-1:0] b);
        return min_mode ? (a < b) : (a > b);
    endfunction

    // 255*(299R + 587G + 114B) + 100A
    function automatic logic [KEY_W-1:0] luma_key(input logic [7:0] red,
                                                  input logic [7:0] green,
                                                  input logic [7:0] blue,
                                                  input logic [7:0] alpha);
        logic [17:0]      wsum;
        logic [KEY_W-1:0] w;
        wsum = 18'(red) * 18'd299 + 18'(green) * 18'd587 + 18'(blue) * 18'd114;
        w    = KEY_W'(wsum);
        return (w << 8) - w + KEY_W'(alpha) * KEY_W'(100);
    endfunction

endpackage

FILE: hdl/line_window_max_min_by_luma.sv
// ----------------------------------------------------------------------------
// line_window_max_min_by_luma
// Sliding max/min filter over one line of ARGB pixels, keyed on luma+alpha.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel takes one pixel a beat, in line order. m_ channel gives the
//   whole pixel with the best key in the window of +/- radius around each
//   position, m_tlast on the last position of the line. Position i leaves
//   after pixel min(i+radius, n-1) has been taken; the last pixel of a line
//   flushes every pending position.
//   cfg_ write channel: index 0 radius, 1 min_mode, 2 line_length; always
//   ready; a write to any of these restarts the line. Write only while the block is idle.
// Sequence: one pixel at a time; the next pixel is taken only after the last is
//   through. Each pixel is stored; each block end (2*radius+1 pixels) adds a
//   suffix sweep; each output adds a block-crossing pick or a scan of the
//   pixels inside one block, and each further position flushed at line end
//   adds one more pick.
// Reset: aresetn low clears positions and loads radius 1, max mode, 1920.
//   Window memories need no clearing.
// Stall: a result waits in the output register; while it waits the next
//   pixel is still taken, and the block pauses only when a new result is due.
// ----------------------------------------------------------------------------
module line_window_max_min_by_luma
    import lwmm_pkg::*;
#(
    parameter int MAX_RADIUS = MAX_RADIUS_DEF,
    parameter int MAX_LINE   = MAX_LINE_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [PIX_W-1:0]      s_tdata,   // red, green, blue, alpha
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [PIX_W-1:0]      m_tdata,   // out_red, out_green, out_blue, out_alpha
    output logic                  m_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    lwmm_cmd_t  cmd;
    lwmm_stat_t stat;

    assign cfg_ready = 1'b1;

    lwmm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lwmm_dp #(
        .MAX_RADIUS (MAX_RADIUS),
        .MAX_LINE   (MAX_LINE)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

FILE: hdl/lwmm_ram.sv
// ----------------------------------------------------------------------------
// lwmm_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lwmm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        // hold read data while idle
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/lwmm_ctrl.sv
// ----------------------------------------------------------------------------
// lwmm_ctrl
// Sequencer: steps one pixel through store, block-end sweep and output picks.
// ----------------------------------------------------------------------------
module lwmm_ctrl
    import lwmm_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  lwmm_stat_t stat,
    output lwmm_cmd_t  cmd
);

    typedef enum logic [11:0] {
        ST_IDLE     = 12'b0000_0000_0001,
        ST_STORE    = 12'b0000_0000_0010,
        ST_SUF_RD   = 12'b0000_0000_0100,
        ST_SUF_WR   = 12'b0000_0000_1000,
        ST_EMIT_CHK = 12'b0000_0001_0000,
        ST_SCAN_RD  = 12'b0000_0010_0000,
        ST_SCAN_CMP = 12'b0000_0100_0000,
        ST_XB_RD    = 12'b0000_1000_0000,
        ST_XB_SEL   = 12'b0001_0000_0000,
        ST_PIX_RD   = 12'b0010_0000_0000,
        ST_PIX_OUT  = 12'b0100_0000_0000,
        ST_ADVANCE  = 12'b1000_0000_0000
    } lwmm_state_t;

    lwmm_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_STORE;
                end
            end
            ST_STORE: begin
                cmd.store = 1'b1;
                if (stat.end_blk && !stat.r_zero) begin
                    state_next = ST_SUF_RD;
                end else begin
                    state_next = ST_EMIT_CHK;
                end
            end
            ST_SUF_RD: begin
                cmd.suf_rd = 1'b1;
                state_next = ST_SUF_WR;
            end
            ST_SUF_WR: begin
                cmd.suf_step = 1'b1;
                state_next   = stat.suf_last ? ST_EMIT_CHK : ST_SUF_RD;
            end
            ST_EMIT_CHK: begin
                if (!stat.need_emit) begin
                    state_next = ST_ADVANCE;
                end else if (stat.same_blk) begin
                    cmd.scan_init = 1'b1;
                    state_next    = ST_SCAN_RD;
                end else begin
                    state_next = ST_XB_RD;
                end
            end
            ST_SCAN_RD: begin
                cmd.scan_rd = 1'b1;
                state_next  = ST_SCAN_CMP;
            end
            ST_SCAN_CMP: begin
                cmd.scan_step = 1'b1;
                state_next    = stat.scan_done ? ST_PIX_RD : ST_SCAN_RD;
            end
            ST_XB_RD: begin
                cmd.xb_rd  = 1'b1;
                state_next = ST_XB_SEL;
            end
            ST_XB_SEL: begin
                cmd.xb_sel = 1'b1;
                state_next = ST_PIX_RD;
            end
            ST_PIX_RD: begin
                cmd.pix_rd = 1'b1;
                state_next = ST_PIX_OUT;
            end
            ST_PIX_OUT: begin
                // wait for the output register to drain
                if (stat.out_free) begin
                    cmd.emit = 1'b1;
                    if (stat.line_last && !stat.at_final) begin
                        state_next = ST_EMIT_CHK;
                    end else begin
                        state_next = ST_ADVANCE;
                    end
                end
            end
            ST_ADVANCE: begin
                cmd.advance = 1'b1;
                state_next  = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/lwmm_dp.sv
// ----------------------------------------------------------------------------
// lwmm_dp
// Datapath: config registers, position counters, window memories, block
// prefix/suffix bests and the output register.
// ----------------------------------------------------------------------------
module lwmm_dp
    import lwmm_pkg::*;
#(
    parameter int MAX_RADIUS = MAX_RADIUS_DEF,
    parameter int MAX_LINE   = MAX_LINE_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [PIX_W-1:0]      s_tdata,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  m_tready,
    output logic                  m_tvalid,
    output logic [PIX_W-1:0]      m_tdata,
    output logic                  m_tlast,
    input  lwmm_cmd_t             cmd,
    output lwmm_stat_t            stat
);

    localparam int RING_DEPTH = 2 * MAX_RADIUS + 2;
    localparam int SLOT_W     = $clog2(RING_DEPTH);
    localparam int POS_W      = $clog2(MAX_LINE);
    localparam int R_W        = $clog2(MAX_RADIUS + 1);
    localparam int SUF_W      = KEY_W + SLOT_W;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(RING_DEPTH - 1)) ? '0 : s + 1'b1;
    endfunction

    function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] s);
        return (s == '0) ? SLOT_W'(RING_DEPTH - 1) : s - 1'b1;
    endfunction

    // configuration
    logic [RADIUS_W-1:0] radius_reg;
    logic                min_mode_reg;
    logic [LEN_W-1:0]    line_length_reg;

    // positions
    logic [POS_W-1:0]  j_pos_reg, out_pos_reg, sl_pos_reg;
    logic [SLOT_W-1:0] in_slot_reg, phase_reg, sl_slot_reg;

    // item and block bests
    logic [PIX_W-1:0]  cap_pix_reg;
    logic [KEY_W-1:0]  cap_key_reg, pre_key_reg, cur_key_reg, best_key_reg;
    logic [SLOT_W-1:0] pre_slot_reg, cur_slot_reg, lo_slot_reg, ptr_reg, sel_slot_reg;
    logic [SLOT_W-1:0] suf_cnt_reg;
    logic [POS_W-1:0]  rem_reg;
    logic              first_reg;

    // output register
    logic              out_valid_reg, out_last_reg;
    logic [PIX_W-1:0]  out_pix_reg;

    logic [R_W-1:0]    r_eff;
    logic [SLOT_W-1:0] two_r;
    logic [POS_W-1:0]  nm1;
    logic [31:0]       rad32, len32, n32;
    logic              restart;

    logic [PIX_W-1:0]  pix_rdata;
    logic [KEY_W-1:0]  key_rdata;
    logic [SUF_W-1:0]  suf_rdata;
    logic [KEY_W-1:0]  suf_rd_key;
    logic [SLOT_W-1:0] suf_rd_slot;
    logic              step_better;
    logic [KEY_W-1:0]  step_key;
    logic [SLOT_W-1:0] step_slot;
    logic              suf_we;
    logic [SLOT_W-1:0] suf_waddr, key_raddr;
    logic [SUF_W-1:0]  suf_wdata;

    always_comb begin
        rad32 = 32'(radius_reg);
        r_eff = (rad32 > 32'(MAX_RADIUS)) ? R_W'(MAX_RADIUS) : R_W'(rad32);
        two_r = SLOT_W'(32'(r_eff) << 1);
        len32 = 32'(line_length_reg);
        if (len32 == 32'd0) begin
            n32 = 32'd1;
        end else if (len32 > 32'(MAX_LINE)) begin
            n32 = 32'(MAX_LINE);
        end else begin
            n32 = len32;
        end
        nm1 = POS_W'(n32 - 32'd1);
    end

    always_comb begin
        restart = 1'b0;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_RADIUS, REG_MIN_MODE, REG_LINE_LENGTH: restart = 1'b1;
                default:                                   restart = 1'b0;
            endcase
        end
    end

    assign {suf_rd_key, suf_rd_slot} = suf_rdata;
    assign step_better = better(min_mode_reg, key_rdata, cur_key_reg);
    assign step_key    = step_better ? key_rdata : cur_key_reg;
    assign step_slot   = step_better ? lo_slot_reg : cur_slot_reg;

    assign stat.end_blk   = (phase_reg == two_r);
    assign stat.r_zero    = (r_eff == '0);
    assign stat.suf_last  = (suf_cnt_reg == SLOT_W'(1));
    assign stat.need_emit = (j_pos_reg == nm1) ||
                            (32'(out_pos_reg) + 32'(r_eff) <= 32'(j_pos_reg));
    assign stat.same_blk  = (32'(sl_pos_reg) >= 32'(j_pos_reg) - 32'(phase_reg));
    assign stat.scan_done = (rem_reg == '0);
    assign stat.out_free  = !out_valid_reg || m_tready;
    assign stat.line_last = (j_pos_reg == nm1);
    assign stat.at_final  = (out_pos_reg == nm1);

    assign suf_we    = (cmd.store && stat.end_blk) || cmd.suf_step;
    assign suf_waddr = cmd.store ? in_slot_reg : lo_slot_reg;
    assign suf_wdata = cmd.store ? {cap_key_reg, in_slot_reg} : {step_key, step_slot};
    assign key_raddr = cmd.suf_rd ? lo_slot_reg : ptr_reg;

    lwmm_ram #(.WIDTH(PIX_W), .DEPTH(RING_DEPTH)) u_pix_ram (
        .aclk  (aclk),
        .we    (cmd.store),
        .waddr (in_slot_reg),
        .wdata (cap_pix_reg),
        .re    (cmd.pix_rd),
        .raddr (sel_slot_reg),
        .rdata (pix_rdata)
    );

    lwmm_ram #(.WIDTH(KEY_W), .DEPTH(RING_DEPTH)) u_key_ram (
        .aclk  (aclk),
        .we    (cmd.store),
        .waddr (in_slot_reg),
        .wdata (cap_key_reg),
        .re    (cmd.suf_rd || cmd.scan_rd),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    lwmm_ram #(.WIDTH(SUF_W), .DEPTH(RING_DEPTH)) u_suf_ram (
        .aclk  (aclk),
        .we    (suf_we),
        .waddr (suf_waddr),
        .wdata (suf_wdata),
        .re    (cmd.xb_rd),
        .raddr (sl_slot_reg),
        .rdata (suf_rdata)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg      <= RADIUS_RST;
            min_mode_reg    <= 1'b0;
            line_length_reg <= LINE_LENGTH_RST;
            j_pos_reg       <= '0;
            in_slot_reg     <= '0;
            phase_reg       <= '0;
            out_pos_reg     <= '0;
            sl_pos_reg      <= '0;
            sl_slot_reg     <= '0;
            pre_key_reg     <= '0;
            pre_slot_reg    <= '0;
            first_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_RADIUS:      radius_reg      <= cfg_data[RADIUS_W-1:0];
                    REG_MIN_MODE:    min_mode_reg    <= cfg_data[0];
                    REG_LINE_LENGTH: line_length_reg <= cfg_data[LEN_W-1:0];
                    default:         ;
                endcase
            end
            if (cmd.store && (phase_reg == '0 ||
                              better(min_mode_reg, cap_key_reg, pre_key_reg))) begin
                pre_key_reg  <= cap_key_reg;
                pre_slot_reg <= in_slot_reg;
            end
            if (cmd.scan_init) begin
                first_reg <= 1'b1;
            end else if (cmd.scan_step) begin
                first_reg <= 1'b0;
            end
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
                out_pos_reg   <= out_pos_reg + 1'b1;
                // left edge moves once the window is past the line start
                if (32'(out_pos_reg) >= 32'(r_eff)) begin
                    sl_pos_reg  <= sl_pos_reg + 1'b1;
                    sl_slot_reg <= slot_inc(sl_slot_reg);
                end
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (restart || (cmd.advance && stat.line_last)) begin
                j_pos_reg   <= '0;
                in_slot_reg <= '0;
                phase_reg   <= '0;
                out_pos_reg <= '0;
                sl_pos_reg  <= '0;
                sl_slot_reg <= '0;
            end else if (cmd.advance) begin
                j_pos_reg   <= j_pos_reg + 1'b1;
                in_slot_reg <= slot_inc(in_slot_reg);
                phase_reg   <= stat.end_blk ? '0 : phase_reg + 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            cap_pix_reg <= s_tdata;
            cap_key_reg <= luma_key(s_tdata[7:0], s_tdata[15:8], s_tdata[23:16],
                                    s_tdata[31:24]);
        end
        if (cmd.store) begin
            cur_key_reg  <= cap_key_reg;
            cur_slot_reg <= in_slot_reg;
            lo_slot_reg  <= slot_dec(in_slot_reg);
            suf_cnt_reg  <= two_r;
        end
        if (cmd.suf_step) begin
            cur_key_reg  <= step_key;
            cur_slot_reg <= step_slot;
            lo_slot_reg  <= slot_dec(lo_slot_reg);
            suf_cnt_reg  <= suf_cnt_reg - 1'b1;
        end
        if (cmd.scan_init) begin
            ptr_reg <= sl_slot_reg;
            rem_reg <= j_pos_reg - sl_pos_reg;
        end
        if (cmd.scan_step) begin
            // leftmost wins on a tie
            if (first_reg || better(min_mode_reg, key_rdata, best_key_reg)) begin
                best_key_reg <= key_rdata;
                sel_slot_reg <= ptr_reg;
            end
            ptr_reg <= slot_inc(ptr_reg);
            rem_reg <= rem_reg - 1'b1;
        end
        if (cmd.xb_sel) begin
            sel_slot_reg <= better(min_mode_reg, pre_key_reg, suf_rd_key) ?
                            pre_slot_reg : suf_rd_slot;
        end
        if (cmd.emit) begin
            out_pix_reg  <= pix_rdata;
            out_last_reg <= stat.at_final;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_pix_reg;
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> stat.out_free)
        else $error("output beat overwritten before it was taken");

    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg <= two_r)
        else $error("block phase beyond block length");

    a_left_edge: assert property (@(posedge aclk) disable iff (!aresetn)
        sl_pos_reg <= out_pos_reg)
        else $error("window left edge ahead of output position");

    a_line_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.advance && stat.line_last) |=> (j_pos_reg == '0 && out_pos_reg == '0))
        else $error("positions not cleared at line end");
`endif

endmodule

FILE: tb/sv/line_window_max_min_by_luma_chk.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_window_max_min_by_luma_chk
// Watches the pixel, result and register channels of the line window filter,
// predicts each output pixel from the accepted input beats and compares it,
// field by field, with the beats that leave the block.
// ----------------------------------------------------------------------------
module line_window_max_min_by_luma_chk
    import lwmm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [PIX_W-1:0]      s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [PIX_W-1:0]      m_tdata,
    input  logic                  m_tlast,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    errors,
    output int                    pending
);

    localparam int RING = 128;

    typedef struct {
        logic [KEY_W-1:0] key;
        int               slot;
    } best_t;

    typedef struct {
        logic [PIX_W-1:0] pix;
        logic             last;
    } out_pix_t;

    logic [RADIUS_W-1:0] radius;
    logic                min_mode;
    logic [LEN_W-1:0]    line_len;

    logic [PIX_W-1:0]    ring_pix [RING];
    logic [KEY_W-1:0]    ring_key [RING];
    best_t               run_best;
    best_t               tail_best [RING];
    int                  in_pos;
    int                  out_pos;
    out_pix_t            expected_pix [$];

    initial errors = 0;
    initial pending = 0;

    function automatic logic beats(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b);
        return min_mode ? (a < b) : (a > b);
    endfunction

    function automatic logic [KEY_W-1:0] luma_of(input logic [PIX_W-1:0] d);
        int w;
        w = 255 * (299 * int'(d[7:0]) + 587 * int'(d[15:8]) + 114 * int'(d[23:16]))
            + 100 * int'(d[31:24]);
        return KEY_W'(w);
    endfunction

    // ring slot holding the winner for position i, window ending at sr
    function automatic int winner_slot(input int i, input int sr, input int r);
        int    blen;
        int    sl;
        int    sel;
        best_t c;
        blen = 2 * r + 1;
        sl   = (i >= r) ? i - r : 0;
        if (sl / blen == sr / blen) begin
            sel = sl % RING;
            for (int p = sl + 1; p <= sr; p++)
                if (beats(ring_key[p % RING], ring_key[sel])) sel = p % RING;
        end else begin
            c = tail_best[sl % RING];
            if (beats(run_best.key, c.key)) c = run_best;
            sel = c.slot;
        end
        return sel;
    endfunction

    task automatic take_pixel(input logic [PIX_W-1:0] d);
        int               r;
        int               n;
        int               blen;
        int               j;
        int               s;
        int               b;
        int               cnt;
        logic [KEY_W-1:0] k;
        r    = int'(radius);
        n    = (line_len == 0) ? 1 : (int'(line_len) > 4096 ? 4096 : int'(line_len));
        blen = 2 * r + 1;
        j    = in_pos;
        s    = j % RING;
        k    = luma_of(d);
        cnt  = 0;
        ring_pix[s] = d;
        ring_key[s] = k;
        if (j % blen == 0 || beats(k, run_best.key)) run_best = '{k, s};
        // block complete: sweep suffix bests from its end back to its start
        if (j % blen == blen - 1) begin
            b = j + 1 - blen;
            tail_best[s] = '{k, s};
            for (int p = j; p > b; p--) begin
                if (beats(ring_key[(p - 1) % RING], tail_best[p % RING].key))
                    tail_best[(p - 1) % RING] = '{ring_key[(p - 1) % RING], (p - 1) % RING};
                else
                    tail_best[(p - 1) % RING] = tail_best[p % RING];
            end
        end
        if (j == n - 1) begin
            while (out_pos < n && cnt < 64) begin
                expected_pix.push_back('{ring_pix[winner_slot(out_pos, j, r)], out_pos == n - 1});
                out_pos++;
                cnt++;
            end
            in_pos  = 0;
            out_pos = 0;
        end else begin
            if (out_pos + r <= j) begin
                expected_pix.push_back('{ring_pix[winner_slot(out_pos, j, r)], out_pos == n - 1});
                out_pos++;
            end
            in_pos = j + 1;
        end
    endtask

    always @(posedge aclk) begin
        out_pix_t want;
        if (!aresetn) begin
            radius   = RADIUS_RST;
            min_mode = 1'b0;
            line_len = LINE_LENGTH_RST;
            run_best = '{'0, 0};
            in_pos   = 0;
            out_pos  = 0;
            expected_pix.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_RADIUS:      radius   = cfg_data[RADIUS_W-1:0];
                    REG_MIN_MODE:    min_mode = cfg_data[0];
                    REG_LINE_LENGTH: line_len = cfg_data[LEN_W-1:0];
                    default: ;
                endcase
                if (cfg_index inside {REG_RADIUS, REG_MIN_MODE, REG_LINE_LENGTH}) begin
                    in_pos  = 0;
                    out_pos = 0;
                end
            end
            if (s_tvalid && s_tready) take_pixel(s_tdata);
            if (m_tvalid && m_tready) begin
                if (expected_pix.size() == 0) begin
                    $display("%0t: unexpected beat, expected none, got %h last %0b",
                             $realtime, m_tdata, m_tlast);
                    errors++;
                end else begin
                    want = expected_pix.pop_front();
                    if (m_tdata[7:0] !== want.pix[7:0] || m_tdata[15:8] !== want.pix[15:8] ||
                        m_tdata[23:16] !== want.pix[23:16] ||
                        m_tdata[31:24] !== want.pix[31:24] || m_tlast !== want.last) begin
                        $display("%0t: mismatch, expected %h last %0b, got %h last %0b",
                                 $realtime, want.pix, want.last, m_tdata, m_tlast);
                        errors++;
                    end
                end
            end
        end
        pending = expected_pix.size();
    end

endmodule

FILE: tb/sv/line_window_max_min_by_luma_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_window_max_min_by_luma_tb
// Drives pixel lines through the line window filter under several register
// settings, with random gaps on both channels, a long output hold-off and
// drained pauses; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module line_window_max_min_by_luma_tb;
    import lwmm_pkg::*;

    localparam int WATCHDOG = 30000;
    localparam int SETTLE   = 700;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [PIX_W-1:0]      s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [PIX_W-1:0]      m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    errors;
    int                    pending;

    int   pixels_sent = 0;
    int   beats_out   = 0;
    int   quiet       = 0;
    logic calm        = 1'b0;
    logic held_off    = 1'b0;

    line_window_max_min_by_luma dut (.*);

    line_window_max_min_by_luma_chk chk (.*);

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // watchdog: no beat on any channel for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (m_tvalid && m_tready) beats_out <= beats_out + 1;
        if (quiet >= WATCHDOG) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver: random stalls, one long hold-off while pixels keep coming
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (!held_off && beats_out >= 150 && s_tvalid) begin
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
                held_off = 1'b1;
            end
            m_tready <= calm || ($urandom_range(99) >= 7);
        end
    end

    task automatic send_pixel(input logic [PIX_W-1:0] d);
        logic ok;
        while (!calm && $urandom_range(99) < 7) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do begin
            @(negedge aclk);
            ok = s_tready;
            @(posedge aclk);
        end while (!ok);
        pixels_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        logic ok;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
        do begin
            @(negedge aclk);
            ok = cfg_ready;
            @(posedge aclk);
        end while (!ok);
        cfg_valid <= 1'b0;
    endtask

    task automatic setup(input int r, input int mode, input int n);
        write_reg(REG_RADIUS, r);
        write_reg(REG_MIN_MODE, mode);
        write_reg(REG_LINE_LENGTH, n);
    endtask

    // distinct pixels of equal key: R+1,B+157 matches G+31
    function automatic logic [PIX_W-1:0] tie_pixel(input logic pick, input logic [7:0] a);
        return pick ? {a, 8'd157, 8'd50, 8'd101} : {a, 8'd0, 8'd81, 8'd100};
    endfunction

    function automatic logic [PIX_W-1:0] any_pixel();
        case ($urandom_range(7))
            0, 1: return tie_pixel($urandom_range(1), 8'($urandom_range(2) * 127));
            2:    return $urandom_range(1) ? 32'h0000_0000 : 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_line(input int cnt);
        for (int i = 0; i < cnt; i++) send_pixel(any_pixel());
    endtask

    initial begin
        int r;
        int n;
        int phase;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_RADIUS;
        cfg_data  = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings, partial line
        for (int i = 0; i < 5; i++) send_pixel(any_pixel());
        drain();

        // pass-through with channel extremes
        setup(0, 0, 8);
        send_pixel(32'h0000_0000);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h0000_00FF);
        send_pixel(32'h0000_FF00);
        send_pixel(32'h00FF_0000);
        send_pixel(32'hFF00_0000);
        send_pixel(tie_pixel(1'b0, 8'd7));
        send_pixel(tie_pixel(1'b1, 8'd7));
        drain();

        // min mode, ties within and across blocks
        setup(2, 1, 10);
        send_pixel(tie_pixel(1'b0, 8'd0));
        send_pixel(32'hFFFF_FFFF);
        send_pixel(tie_pixel(1'b1, 8'd0));
        send_pixel(tie_pixel(1'b0, 8'd0));
        send_pixel(tie_pixel(1'b1, 8'd0));
        send_pixel(32'hFFFF_FFFF);
        send_pixel(tie_pixel(1'b1, 8'd0));
        send_pixel(tie_pixel(1'b0, 8'd0));
        send_pixel(32'h8000_0000);
        send_pixel(tie_pixel(1'b0, 8'd0));
        drain();

        // zero length counts as one
        setup(5, 0, 0);
        send_pixel(32'h1234_5678);
        send_pixel(32'h9ABC_DEF0);
        drain();

        phase = 0;
        while (pixels_sent < 370) begin
            calm = (phase == 3);
            case (phase)
                1: begin
                    setup(63, 0, 70);
                    send_line(70);
                end
                2: begin
                    setup(63, 1, 4096);
                    send_line(40);
                end
                4: begin
                    setup(3, 0, 8191);
                    send_line(30);
                end
                default: begin
                    r = ($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(7);
                    n = $urandom_range(3 * r + 20, 1);
                    // trim the line so the run ends near its pixel budget
                    if (n > 370 - pixels_sent) n = (370 - pixels_sent > 0) ? 370 - pixels_sent : 1;
                    setup(r | ($urandom_range(127) << 6), $urandom_range(1), n);
                    send_line(n);
                end
            endcase
            drain();
            phase++;
        end
        calm = 1'b0;
        drain();

        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
